// ===== hdl/psc_pkg.sv =====
// psc_pkg: shared constants for the pid speed controller
// fixed field widths, configuration register indexes and queue depth
// no dependencies
package psc_pkg;

  // fixed field widths
  localparam int GAIN_BITS  = 16;
  localparam int DRIVE_BITS = 16;
  localparam int SEL_BITS   = 2;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROPORTIONAL_GAIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEGRAL_GAIN     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DERIVATIVE_GAIN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_SELECT      = 2'd3;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // gain settings handed from the register file to the front
  typedef struct packed {
    logic [GAIN_BITS-1:0] kp;
    logic [GAIN_BITS-1:0] ki;
    logic [GAIN_BITS-1:0] kd;
  } gains_t;

endpackage

// ===== hdl/psc_if.sv =====
// psc_if: valid/ready channel interfaces of the pid speed controller
// tick channel (psc_in_if) and drive channel (psc_out_if); uses psc_pkg
interface psc_in_if #(
  parameter int SPEED_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] target_speed;
  logic signed [SPEED_WIDTH-1:0] measured_speed;
  logic                          motion_enabled;

  modport source (output valid, output target_speed, output measured_speed,
                  output motion_enabled, input ready);
  modport sink (input valid, input target_speed, input measured_speed,
                input motion_enabled, output ready);
endinterface

interface psc_out_if ();
  logic                                   valid;
  logic                                   ready;
  logic signed [psc_pkg::DRIVE_BITS-1:0]  drive_value;
  logic [psc_pkg::SEL_BITS-1:0]           motor_channel;

  modport source (output valid, output drive_value, output motor_channel, input ready);
  modport sink (input valid, input drive_value, input motor_channel, output ready);
endinterface

// ===== hdl/pid_speed_controller.sv =====
// pid_speed_controller: top level, configuration registers and wiring
// uses psc_pkg, psc_if, psc_front, psc_queue, psc_back
//
// PID speed controller with derivative on measurement.
// Tick beats arrive on in_chan (target speed, measured speed, motion flag).
// A tick with the motion flag set yields one drive beat on out_chan carrying
// the saturated signed 16-bit drive and the motor channel from motor_select.
// A tick with the flag clear yields no beat; it clears the integral and the
// previous speed if the previous speed was nonzero.
// Gains and motor_select are written through cfg_wr_en/cfg_index/cfg_wdata; the
// user writes them only while no tick is in flight, the block does not enforce it.
// A drive beat passes through the queue, stage one and the output register.
// One tick per cycle is taken while the queue has room; the integral update in
// the back loops on the integral register, the three gain products of the
// tick sit in the front and kd times the previous speed is formed in the back.
// A four-entry queue decouples front and back; when the receiver stalls
// the output register and the stage before it hold, the queue fills and
// in_chan.ready drops only once it is full.
// Reset (rst_n low at a clock edge) clears gains, channel select, integral,
// previous speed and all pipeline and queue occupancy.
module pid_speed_controller #(
  parameter int SPEED_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  psc_in_if.sink                            in_chan,
  psc_out_if.source                         out_chan,
  input  logic                              cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [psc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int PROD_W  = psc_pkg::GAIN_BITS + SPEED_WIDTH + 2;
  localparam int ENTRY_W = 3 * PROD_W + SPEED_WIDTH + 1;

  psc_pkg::gains_t              gains_r, gains_nxt;
  logic [psc_pkg::SEL_BITS-1:0] motor_select_r, motor_select_nxt;

  logic               q_push, q_not_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_push_data, q_head_data;

  // configuration register writes
  always_comb begin
    gains_nxt        = gains_r;
    motor_select_nxt = motor_select_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        psc_pkg::REG_PROPORTIONAL_GAIN: gains_nxt.kp = cfg_wdata[psc_pkg::GAIN_BITS-1:0];
        psc_pkg::REG_INTEGRAL_GAIN:     gains_nxt.ki = cfg_wdata[psc_pkg::GAIN_BITS-1:0];
        psc_pkg::REG_DERIVATIVE_GAIN:   gains_nxt.kd = cfg_wdata[psc_pkg::GAIN_BITS-1:0];
        psc_pkg::REG_MOTOR_SELECT: begin
          motor_select_nxt = cfg_wdata[psc_pkg::SEL_BITS-1:0];
        end
        default: begin
          gains_nxt = gains_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r        <= '0;
      motor_select_r <= '0;
    end else begin
      gains_r        <= gains_nxt;
      motor_select_r <= motor_select_nxt;
    end
  end

  // front: accept and form products
  psc_front #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .PROD_W      (PROD_W)
  ) u_front (
    .in_chan    (in_chan),
    .gains      (gains_r),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  // decoupling queue
  psc_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head_data)
  );

  // back: state update and drive
  psc_back #(
    .SPEED_WIDTH    (SPEED_WIDTH),
    .PROD_W         (PROD_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_head_data),
    .q_pop        (q_pop),
    .kd           (gains_r.kd),
    .motor_select (motor_select_r),
    .out_chan     (out_chan)
  );

endmodule

// ===== hdl/psc_queue.sv =====
// psc_queue: short register queue between the front and the back
// depth from psc_pkg::QUEUE_DEPTH, payload width set by parameter
module psc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = psc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full   = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = store_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) push |-> (not_full || pop);
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("queue written while full");

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) pop |-> head_valid;
  endproperty
  a_no_underflow: assert property (p_no_underflow)
    else $error("queue popped while empty");

  property p_count_range;
    @(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH);
  endproperty
  a_count_range: assert property (p_count_range)
    else $error("queue fill count beyond depth");

endmodule

// ===== hdl/psc_front.sv =====
// psc_front: accepts tick beats, forms the error and the three gain products
// and classifies the tick as a run or idle entry; uses psc_pkg, psc_in_if
module psc_front #(
  parameter int SPEED_WIDTH = 16,
  parameter int PROD_W      = 34
) (
  psc_in_if.sink                          in_chan,
  input  psc_pkg::gains_t                 gains,
  input  logic                            q_not_full,
  output logic                            q_push,
  output logic [3*PROD_W+SPEED_WIDTH:0]   q_data
);

  logic signed [psc_pkg::GAIN_BITS:0] kp_s, ki_s, kd_s;
  logic signed [SPEED_WIDTH:0]        err;
  logic signed [PROD_W-1:0]           kp_err, ki_err, kd_meas;

  // accept whenever the queue has room
  assign in_chan.ready = q_not_full;
  assign q_push        = in_chan.valid && q_not_full;

  // gains are unsigned, widen with a zero sign bit
  assign kp_s = $signed({1'b0, gains.kp});
  assign ki_s = $signed({1'b0, gains.ki});
  assign kd_s = $signed({1'b0, gains.kd});

  // error one bit wider than the speeds so it cannot wrap
  assign err = $signed({in_chan.target_speed[SPEED_WIDTH-1], in_chan.target_speed})
             - $signed({in_chan.measured_speed[SPEED_WIDTH-1], in_chan.measured_speed});

  // products carry the gain fraction bits
  assign kp_err  = kp_s * err;
  assign ki_err  = ki_s * err;
  assign kd_meas = kd_s * in_chan.measured_speed;

  // measured speed travels along so the back keeps the previous speed itself
  assign q_data = {in_chan.motion_enabled, in_chan.measured_speed, kp_err, ki_err, kd_meas};

endmodule

// ===== hdl/psc_back.sv =====
// psc_back: carries out queued ticks: integral update, state clear on idle,
// drive sum, floor shift and saturation; uses psc_pkg, psc_out_if
module psc_back #(
  parameter int SPEED_WIDTH    = 16,
  parameter int PROD_W         = 34,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [3*PROD_W+SPEED_WIDTH:0] q_data,
  output logic                          q_pop,
  input  logic [psc_pkg::GAIN_BITS-1:0] kd,
  input  logic [psc_pkg::SEL_BITS-1:0]  motor_select,
  psc_out_if.source                     out_chan
);

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int DW    = psc_pkg::DRIVE_BITS;
  localparam int SUM_W = ((PROD_W > IW) ? PROD_W : IW) + 1;
  localparam int PD_W  = PROD_W + 2;
  localparam int ACC_W = ((PD_W > IW) ? PD_W : IW) + 1;

  localparam logic signed [SUM_W-1:0] INT_HI = {{(SUM_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] INT_LO = ~INT_HI;
  localparam logic signed [ACC_W-1:0] DRV_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DRV_LO = ~DRV_HI;

  // queue entry fields
  logic                          ent_en;
  logic signed [SPEED_WIDTH-1:0] ent_meas;
  logic signed [PROD_W-1:0]      ent_kp_err, ent_ki_err, ent_kd_meas;

  // controller state
  logic signed [IW-1:0]          integral_r, integral_nxt;
  logic signed [SPEED_WIDTH-1:0] prev_speed_r, prev_speed_nxt;
  logic                          prev_nz;

  // first stage: proportional/derivative sum and new integral
  logic                     p1_valid_r, p1_valid_nxt;
  logic signed [PD_W-1:0]   p1_pd_r;
  logic signed [IW-1:0]     p1_int_r;
  logic                     p1_move, p1_free;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]         out_drive_r;
  logic [psc_pkg::SEL_BITS-1:0] out_chan_r;

  logic                               pop_run, pop_idle;
  logic signed [psc_pkg::GAIN_BITS:0] kd_s;
  logic signed [PROD_W-1:0]           kd_prev;
  logic signed [SUM_W-1:0]            int_sum;
  logic signed [PD_W-1:0]             pd;
  logic signed [ACC_W-1:0]            acc, acc_sh;
  logic signed [DW-1:0]               drive;

  assign ent_en      = q_data[3*PROD_W+SPEED_WIDTH];
  assign ent_meas    = $signed(q_data[3*PROD_W+SPEED_WIDTH-1:3*PROD_W]);
  assign ent_kp_err  = $signed(q_data[3*PROD_W-1:2*PROD_W]);
  assign ent_ki_err  = $signed(q_data[2*PROD_W-1:PROD_W]);
  assign ent_kd_meas = $signed(q_data[PROD_W-1:0]);

  // pipeline advance: output register frees, then stage one
  assign p1_move  = p1_valid_r && (!out_valid_r || out_chan.ready);
  assign p1_free  = !p1_valid_r || p1_move;
  assign q_pop    = q_valid && (!ent_en || p1_free);
  assign pop_run  = q_pop && ent_en;
  assign pop_idle = q_pop && !ent_en;

  // integral accumulate with saturation
  assign int_sum = integral_r + ent_ki_err;

  // derivative on measurement: kd*(m - prev) = kd*m - kd*prev; kd*m comes from the front, kd*prev uses the current kd
  assign kd_s    = $signed({1'b0, kd});
  assign kd_prev = kd_s * prev_speed_r;
  assign prev_nz = (prev_speed_r != '0);
  assign pd      = ent_kp_err - ent_kd_meas + kd_prev;

  // state update for run and idle ticks
  always_comb begin
    integral_nxt   = integral_r;
    prev_speed_nxt = prev_speed_r;
    if (pop_run) begin
      if (int_sum > INT_HI) begin
        integral_nxt = INT_HI[IW-1:0];
      end else if (int_sum < INT_LO) begin
        integral_nxt = INT_LO[IW-1:0];
      end else begin
        integral_nxt = int_sum[IW-1:0];
      end
      prev_speed_nxt = ent_meas;
    end else if (pop_idle && prev_nz) begin
      integral_nxt   = '0;
      prev_speed_nxt = '0;
    end
  end

  // drive: full sum, floor shift, saturate
  assign acc    = p1_pd_r + p1_int_r;
  assign acc_sh = acc >>> GAIN_FRAC_BITS;
  always_comb begin
    if (acc_sh > DRV_HI) begin
      drive = DRV_HI[DW-1:0];
    end else if (acc_sh < DRV_LO) begin
      drive = DRV_LO[DW-1:0];
    end else begin
      drive = acc_sh[DW-1:0];
    end
  end

  assign p1_valid_nxt  = (p1_valid_r && !p1_move) || pop_run;
  assign out_valid_nxt = p1_move || (out_valid_r && !out_chan.ready);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      prev_speed_r <= '0;
      p1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      integral_r   <= integral_nxt;
      prev_speed_r <= prev_speed_nxt;
      p1_valid_r   <= p1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop_run) begin
      p1_pd_r  <= pd;
      p1_int_r <= integral_nxt;
    end
    if (p1_move) begin
      out_drive_r <= drive;
      out_chan_r  <= motor_select;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.drive_value   = out_drive_r;
  assign out_chan.motor_channel = out_chan_r;

  property p_idle_clears;
    @(posedge clk) disable iff (!rst_n)
      (pop_idle && prev_nz) |=> (integral_r == '0 && prev_speed_r == '0);
  endproperty
  a_idle_clears: assert property (p_idle_clears)
    else $error("idle tick did not clear controller state");

  property p_out_holds;
    @(posedge clk) disable iff (!rst_n) (out_valid_r && !out_chan.ready) |=> out_valid_r;
  endproperty
  a_out_holds: assert property (p_out_holds)
    else $error("stalled drive beat dropped");

  property p_stage_holds;
    @(posedge clk) disable iff (!rst_n) (p1_valid_r && !p1_move) |=> p1_valid_r;
  endproperty
  a_stage_holds: assert property (p_stage_holds)
    else $error("stalled stage one entry lost");

  property p_run_needs_slot;
    @(posedge clk) disable iff (!rst_n) pop_run |-> p1_free;
  endproperty
  a_run_needs_slot: assert property (p_run_needs_slot)
    else $error("run tick taken without a free stage");

endmodule

// ===== test/pid_speed_controller_tb.sv =====
// pid_speed_controller_tb: self-checking bench for the pid speed controller
// drives tick beats and gain settings, predicts drive beats and compares them
// depends on psc_pkg, psc_in_if, psc_out_if and pid_speed_controller
`timescale 1ns / 1ps

module pid_speed_controller_tb;

  localparam int SPEED_BITS     = 16;
  localparam int FRAC_BITS      = 8;
  localparam int INTEG_BITS     = 32;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int QUIET_CYCLES   = 8;
  localparam int PHASES         = 10;
  localparam int TICKS_PER_PHASE = 140;
  localparam int REPORT_LIMIT   = 10;
  localparam longint unsigned CYCLE_LIMIT = 300000;

  localparam int DRIVE_W = psc_pkg::DRIVE_BITS;
  localparam int SEL_W   = psc_pkg::SEL_BITS;
  localparam int GAIN_W  = psc_pkg::GAIN_BITS;
  localparam int CFG_W   = psc_pkg::CFG_DATA_BITS;

  typedef logic signed [SPEED_BITS-1:0] speed_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [SEL_W-1:0]          channel;
  } drive_beat_t;

  typedef enum logic {ROW_TICK, ROW_SETTINGS} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    speed_t            target;
    speed_t            measured;
    logic              moving;
    logic              pinned;
    drive_beat_t       pinned_beat;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [CFG_W-1:0]  sel_word;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [psc_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_W-1:0]                 cfg_wdata;

  psc_in_if #(.SPEED_WIDTH(SPEED_BITS)) in_chan_if ();
  psc_out_if out_chan_if ();

  pid_speed_controller #(
    .SPEED_WIDTH(SPEED_BITS),
    .GAIN_FRAC_BITS(FRAC_BITS),
    .INTEGRAL_WIDTH(INTEG_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan_if),
    .out_chan(out_chan_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // controller copy: gain settings and loop state
  logic [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [SEL_W-1:0]  chan_sel;
  longint            integral_acc;
  longint            last_speed;

  drive_beat_t pending_drives[$];
  int          mismatch_count;
  longint unsigned cycle_count;
  int          burst_left;

  // a directed row may pin the expected drive beat
  logic        pin_active;
  drive_beat_t pinned_beat;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic longint sat_signed(input longint x, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // one control tick: integral update, pid sum, floor scaling, saturation
  function automatic void step_controller(input speed_t target, input speed_t measured,
                                          input logic moving, output logic made,
                                          output drive_beat_t beat);
    longint kp_l, ki_l, kd_l;
    longint err, slope, acc;
    kp_l = gain_p;
    ki_l = gain_i;
    kd_l = gain_d;
    made = 1'b0;
    beat = '0;
    if (!moving) begin
      if (last_speed != 0) begin
        integral_acc = 0;
        last_speed = 0;
      end
    end else begin
      err = longint'(target) - longint'(measured);
      slope = longint'(measured) - last_speed;
      integral_acc = sat_signed(integral_acc + ki_l * err, INTEG_BITS);
      acc = kp_l * err - kd_l * slope + integral_acc;
      beat.drive = DRIVE_W'(sat_signed(acc >>> FRAC_BITS, DRIVE_W));
      beat.channel = chan_sel;
      last_speed = longint'(measured);
      made = 1'b1;
    end
  endfunction

  task automatic flag_beat(input string what, input drive_beat_t want,
                           input drive_beat_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected drive %0d ch %0d, got drive %0d ch %0d", $realtime, what,
               $signed(want.drive), want.channel, $signed(got.drive), got.channel);
    end
  endtask

  // check result beats first, then predict from the tick beat of the same edge
  always @(posedge clk) begin : beat_monitor
    drive_beat_t want;
    drive_beat_t got;
    drive_beat_t made_beat;
    logic        made;
    if (rst_n) begin
      if (out_chan_if.valid && out_chan_if.ready) begin
        got.drive = out_chan_if.drive_value;
        got.channel = out_chan_if.motor_channel;
        if (pending_drives.size() == 0) begin
          flag_beat("drive beat with nothing pending", '0, got);
        end else begin
          want = pending_drives.pop_front();
          if (got.drive !== want.drive || got.channel !== want.channel) begin
            flag_beat("drive beat mismatch", want, got);
          end
        end
      end
      if (in_chan_if.valid && in_chan_if.ready) begin
        step_controller(in_chan_if.target_speed, in_chan_if.measured_speed,
                        in_chan_if.motion_enabled, made, made_beat);
        if (made) begin
          pending_drives.push_back(pin_active ? pinned_beat : made_beat);
        end
      end
    end
  end

  // receiver: ready steps through a random 16-bit pattern, redrawn after every fourth pass through it
  initial begin : receiver
    logic [15:0] pattern;
    int unsigned slot;
    pattern = '1;
    slot = 0;
    out_chan_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (slot % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pattern = '1;
          1: pattern = 16'($urandom) | 16'h0001;
          2: pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
          default: pattern = 16'($urandom) | 16'h8000;
        endcase
      end
      out_chan_if.ready <= pattern[slot % 16];
      slot++;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // all four registers in one write burst, called at a falling edge while idle
  task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd,
                               input logic [CFG_W-1:0] sel_word);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= psc_pkg::REG_PROPORTIONAL_GAIN;
    cfg_wdata <= kp;
    @(negedge clk);
    cfg_index <= psc_pkg::REG_INTEGRAL_GAIN;
    cfg_wdata <= ki;
    @(negedge clk);
    cfg_index <= psc_pkg::REG_DERIVATIVE_GAIN;
    cfg_wdata <= kd;
    @(negedge clk);
    cfg_index <= psc_pkg::REG_MOTOR_SELECT;
    cfg_wdata <= sel_word;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gain_p = kp;
    gain_i = ki;
    gain_d = kd;
    chan_sel = sel_word[SEL_W-1:0];
  endtask

  // one tick beat in bursts; pause_after drops valid and waits for all drive beats
  task automatic send_tick(input speed_t target, input speed_t measured, input logic moving,
                           input logic pin, input drive_beat_t pin_beat,
                           input bit pause_after);
    int gap;
    pin_active = pin;
    pinned_beat = pin_beat;
    in_chan_if.valid <= 1'b1;
    in_chan_if.target_speed <= target;
    in_chan_if.measured_speed <= measured;
    in_chan_if.motion_enabled <= moving;
    do @(posedge clk); while (!in_chan_if.ready);
    @(negedge clk);
    gap = 0;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    // a pause always drops valid, even where no gap was drawn
    if (pause_after && gap == 0) begin
      gap = 1;
    end
    if (pause_after || gap > 0) begin
      in_chan_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      while (pause_after && pending_drives.size() != 0) @(negedge clk);
    end
  endtask

  function automatic speed_t to_speed(input int v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return speed_t'(v);
  endfunction

  function automatic row_t tick_row(input int target, input int measured, input logic moving);
    row_t r;
    r = '{kind: ROW_TICK, default: '0};
    r.target = to_speed(target);
    r.measured = to_speed(measured);
    r.moving = moving;
    return r;
  endfunction

  function automatic row_t pinned_row(input int target, input int measured, input int drive,
                                      input int channel);
    row_t r;
    r = tick_row(target, measured, 1'b1);
    r.pinned = 1'b1;
    r.pinned_beat.drive = to_speed(drive);
    r.pinned_beat.channel = SEL_W'(channel);
    return r;
  endfunction

  function automatic row_t settings_row(input int kp, input int ki, input int kd,
                                        input int sel_word);
    row_t r;
    r = '{kind: ROW_SETTINGS, default: '0};
    r.kp = GAIN_W'(kp);
    r.ki = GAIN_W'(ki);
    r.kd = GAIN_W'(kd);
    r.sel_word = CFG_W'(sel_word);
    return r;
  endfunction

  initial begin : stimulus
    row_t   rows[$];
    bit     last_one;
    int     setpoint, r, noise;
    speed_t target, measured;
    logic   moving;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [CFG_W-1:0]  sel_word;

    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= psc_pkg::REG_PROPORTIONAL_GAIN;
    cfg_wdata <= '0;
    in_chan_if.valid <= 1'b0;
    in_chan_if.target_speed <= '0;
    in_chan_if.measured_speed <= '0;
    in_chan_if.motion_enabled <= 1'b0;
    gain_p = '0;
    gain_i = '0;
    gain_d = '0;
    chan_sel = '0;
    integral_acc = 0;
    last_speed = 0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 1;
    pin_active = 1'b0;
    pinned_beat = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // gains zero after reset: drive stays zero on channel zero
    rows.push_back(pinned_row(100, 0, 0, 0));
    rows.push_back(pinned_row(-5, 7, 0, 0));
    rows.push_back(tick_row(0, 0, 1'b0));
    // unity kp, select word with upper bits set lands on channel 3
    rows.push_back(settings_row(16'h0100, 0, 0, 16'hffff));
    rows.push_back(pinned_row(100, 40, 60, 3));
    rows.push_back(tick_row(-3, 0, 1'b1));
    // full gains: drive and integral saturate both ways
    rows.push_back(settings_row(16'hffff, 16'hffff, 16'hffff, 1));
    rows.push_back(pinned_row(32767, -32768, 32767, 1));
    rows.push_back(pinned_row(-32768, 32767, -32768, 1));
    rows.push_back(pinned_row(-32768, 32767, -32768, 1));
    rows.push_back(pinned_row(32767, -32768, 32767, 1));
    rows.push_back(tick_row(0, 0, 1'b0));
    // integral only; idle with zero previous speed keeps the integral
    rows.push_back(settings_row(0, 16'h0080, 0, 2));
    rows.push_back(tick_row(10, 0, 1'b1));
    rows.push_back(tick_row(0, 0, 1'b0));
    rows.push_back(tick_row(0, 0, 1'b1));
    rows.push_back(tick_row(-1, 0, 1'b1));
    // half kp and unity kd: floor rounding of negatives, derivative kick
    rows.push_back(settings_row(16'h0080, 0, 16'h0100, 0));
    rows.push_back(tick_row(1, 1, 1'b1));
    rows.push_back(tick_row(0, 0, 1'b0));
    rows.push_back(tick_row(-3, 0, 1'b1));
    rows.push_back(tick_row(0, 200, 1'b1));
    rows.push_back(tick_row(-32768, -32768, 1'b1));
    rows.push_back(tick_row(32767, 32767, 1'b1));
    rows.push_back(tick_row(-32768, 32767, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_SETTINGS) begin
        load_settings(rows[i].kp, rows[i].ki, rows[i].kd, rows[i].sel_word);
      end else begin
        last_one = (i + 1 == rows.size()) || (rows[i + 1].kind == ROW_SETTINGS);
        send_tick(rows[i].target, rows[i].measured, rows[i].moving, rows[i].pinned,
                  rows[i].pinned_beat, last_one);
      end
    end

    // random phases: motor runs that track a setpoint, with noise and idle ticks
    setpoint = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        kp = '0;
        ki = '0;
        kd = '0;
        sel_word = '0;
      end else if (phase == 1) begin
        kp = '1;
        ki = '1;
        kd = '1;
        sel_word = 16'h0003;
      end else begin
        kp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0300));
        ki = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0040));
        kd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0200));
        sel_word = 16'($urandom);
      end
      load_settings(kp, ki, kd, sel_word);
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          setpoint = int'($urandom_range(0, 4000)) - 2000;
        end
        r = $urandom_range(0, 99);
        moving = (r >= 8);
        if (r < 15 || r >= 92) begin
          target = speed_t'($urandom);
          measured = speed_t'($urandom);
        end else begin
          noise = int'($urandom_range(0, 400)) - 200;
          target = to_speed(setpoint);
          measured = to_speed(setpoint + noise);
        end
        last_one = (k == TICKS_PER_PHASE - 1) ||
                   (phase == 3 && k == TICKS_PER_PHASE / 2) ||
                   ($urandom_range(0, 199) == 0);
        send_tick(target, measured, moving, 1'b0, '0, last_one);
      end
    end

    while (pending_drives.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
